/* rtl/arw_pkg.sv */
// Package for the anti-replay window block: word types, command and status codes.
// No dependencies. Used by anti_replay_window.
`default_nettype none
package arw_pkg;

  localparam int SEQ_W = 40;
  localparam int SEQ_BITS = 40;
  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

  localparam logic [1:0] CMD_VALIDATE = 2'd0;
  localparam logic [1:0] CMD_ROLLBACK = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAX     = 3'd1;
  localparam logic [2:0] ST_EQUAL   = 3'd2;
  localparam logic [2:0] ST_OUTSIDE = 3'd3;
  localparam logic [2:0] ST_REPLAY  = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] seq;
  } cmd_word_t;

  typedef struct packed {
    logic             accepted;
    logic [2:0]       status;
    logic [SEQ_W-1:0] largest_seen;
  } res_word_t;

endpackage
`default_nettype wire

/* rtl/anti_replay_window.sv */
// Anti-replay sliding window: largest sequence, seen bitmap, snapshot and rollback.
// Depends on arw_pkg for word types and codes.
//
//   channel  valid      stall      word
//   command  cmd_valid  cmd_stall  cmd_word (command, seq)
//   result   res_valid  res_stall  res_word (accepted, status, largest_seen)
//
// One word per cycle unless the result stalls; a result is valid once its command
// passes the input and then the result register. The window update is one subtract,
// compare and barrel shift between the two registers. Synchronous reset clears the
// window, the snapshot and both valid flags. A stalled result holds the input register.
`default_nettype none
module anti_replay_window #(
  parameter int WINDOW_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  arw_pkg::cmd_word_t  cmd_word,
  output logic                res_valid,
  input  wire                 res_stall,
  output arw_pkg::res_word_t  res_word
);

  localparam int IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);
  localparam logic [arw_pkg::SEQ_W-1:0] WIN_SPAN = arw_pkg::SEQ_W'(WINDOW_BITS);

  logic                          in_valid;
  arw_pkg::cmd_word_t            in_word;
  logic                          advance;

  logic                          largest_valid;
  logic [arw_pkg::SEQ_W-1:0]     top_seq;
  logic [WINDOW_BITS-1:0]        bitmap;
  logic                          saved_valid;
  logic [arw_pkg::SEQ_W-1:0]     saved_largest;
  logic [WINDOW_BITS-1:0]        saved_bitmap;

  logic                          largest_valid_next;
  logic [arw_pkg::SEQ_W-1:0]     top_seq_next;
  logic [WINDOW_BITS-1:0]        bitmap_next;
  logic                          save;
  logic [2:0]                    status;

  logic [arw_pkg::SEQ_W-1:0]     up;
  logic [arw_pkg::SEQ_W-1:0]     down;
  logic [IDX_W-1:0]              up_idx;
  logic [IDX_W-1:0]              down_idx;

  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = in_valid && !advance;

  assign up       = in_word.seq - top_seq;
  assign down     = top_seq - in_word.seq;
  assign up_idx   = up[IDX_W-1:0];
  assign down_idx = down[IDX_W-1:0];

  always_comb begin
    largest_valid_next = largest_valid;
    top_seq_next       = top_seq;
    bitmap_next        = bitmap;
    save               = 1'b0;
    status             = arw_pkg::ST_OK;
    unique case (in_word.command)
      arw_pkg::CMD_VALIDATE: begin
        save = 1'b1;
        if (in_word.seq >= arw_pkg::SEQ_MAX) begin
          status = arw_pkg::ST_MAX;
        end else if (!largest_valid) begin
          bitmap_next        = WIN_ONE;
          top_seq_next       = in_word.seq;
          largest_valid_next = 1'b1;
        end else if (in_word.seq > top_seq) begin
          if (up >= WIN_SPAN) begin
            bitmap_next = WIN_ONE;
          end else begin
            bitmap_next = (bitmap << up_idx) | WIN_ONE;
          end
          top_seq_next = in_word.seq;
        end else if (in_word.seq == top_seq) begin
          status = arw_pkg::ST_EQUAL;
        end else if (down >= WIN_SPAN) begin
          status = arw_pkg::ST_OUTSIDE;
        end else if (bitmap[down_idx]) begin
          status = arw_pkg::ST_REPLAY;
        end else begin
          bitmap_next = bitmap | (WIN_ONE << down_idx);
        end
      end
      arw_pkg::CMD_ROLLBACK: begin
        largest_valid_next = saved_valid;
        top_seq_next       = saved_largest;
        bitmap_next        = saved_bitmap;
        status             = arw_pkg::ST_DONE;
      end
      arw_pkg::CMD_CLEAR: begin
        largest_valid_next = 1'b0;
        top_seq_next       = '0;
        bitmap_next        = '0;
        status             = arw_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!cmd_stall) begin
      in_valid <= cmd_valid;
    end
    if (!cmd_stall && cmd_valid) begin
      in_word <= cmd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      largest_valid <= 1'b0;
      top_seq       <= '0;
      bitmap        <= '0;
      saved_valid   <= 1'b0;
      saved_largest <= '0;
      saved_bitmap  <= '0;
    end else begin
      if (advance) begin
        res_valid <= in_valid;
      end
      if (advance && in_valid) begin
        largest_valid <= largest_valid_next;
        top_seq       <= top_seq_next;
        bitmap        <= bitmap_next;
        if (in_word.command == arw_pkg::CMD_CLEAR) begin
          saved_valid   <= 1'b0;
          saved_largest <= '0;
          saved_bitmap  <= '0;
        end else if (save) begin
          saved_valid   <= largest_valid;
          saved_largest <= top_seq;
          saved_bitmap  <= bitmap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_word.accepted     <= (in_word.command == arw_pkg::CMD_VALIDATE) &&
                               (status == arw_pkg::ST_OK);
      res_word.status       <= status;
      res_word.largest_seen <= largest_valid_next ? top_seq_next : '0;
    end
  end

endmodule
`default_nettype wire
